[rtl/cau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants for the complex arithmetic unit
// Operation codes, widths, request/response types and divider control types.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_W         = 32;
   localparam int KIND_W         = 3;
   localparam int FRAC_BITS_DEF  = 16;

   typedef enum logic [KIND_W-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4
   } op_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [DATA_W-1:0] a_re;
      logic signed [DATA_W-1:0] a_im;
      logic signed [DATA_W-1:0] b_re;
      logic signed [DATA_W-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] res_re;
      logic signed [DATA_W-1:0] res_im;
      logic                     div_by_zero;
      logic                     equal;
      logic [DATA_W-1:0]        ops_done;
   } rsp_type;

   // control from sequencer to divider
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // saturate sign-magnitude (magnitude up to 64 bits) to 32-bit signed
   function automatic logic signed [DATA_W-1:0] sat_sm(input logic neg,
                                                       input logic [63:0] mag);
      logic signed [DATA_W-1:0] r;
      if (neg) begin
         if (mag >= 64'h8000_0000) r = {1'b1, {(DATA_W-1){1'b0}}};
         else r = -$signed(mag[DATA_W-1:0]);
      end else begin
         if (mag > 64'h7FFF_FFFF) r = {1'b0, {(DATA_W-1){1'b1}}};
         else r = $signed(mag[DATA_W-1:0]);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/cau_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_stream_if: valid/ready channel
// Generic handshake channel carrying one payload of type PAYLOAD_TYPE.
// ----------------------------------------------------------------------------
interface cau_stream_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/complex_arith_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arith_unit: complex add/sub/mul/div/compare on Q16.16 values
// Sequenced datapath around one 32x32 multiplier and one shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries kind and operands A, B; rsp channel returns the last
//   result, the two flags and the operation count. One request is in work at
//   a time; req ready is high only while the sequencer is idle.
//   Add, subtract, compare and unused kinds go from idle straight to the
//   final state, which commits the response.
//   Multiply: four products through one multiplier, then the final state.
//   Divide: six products, the divisor check, then the bit-serial divider,
//   run once per part (real, then imaginary), and the final state.
//   Divide by zero: six products, then the divisor check.
//   While rsp is stalled the response register holds its response and the
//   sequencer waits in its final state before committing the next one.
//   Reset (synchronous) clears the last result, the count and the sequencer.
// ----------------------------------------------------------------------------
module complex_arith_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   cau_stream_if.sink   req,
   cau_stream_if.source rsp
);
   import cau_pkg::*;

   localparam int PW    = 2 * DATA_W + 1;          // sum of two products
   localparam int DEN_W = 2 * DATA_W;
   localparam int NUM_W = DEN_W + FRAC_BITS;

   // multiplier passes: operand pair of each product
   localparam logic [2:0] PASS_RR  = 3'd0;         // a_re * b_re
   localparam logic [2:0] PASS_II  = 3'd1;         // a_im * b_im
   localparam logic [2:0] PASS_IR  = 3'd2;         // a_im * b_re
   localparam logic [2:0] PASS_RI  = 3'd3;         // a_re * b_im
   localparam logic [2:0] PASS_BRR = 3'd4;         // b_re * b_re
   localparam logic [2:0] PASS_BII = 3'd5;         // b_im * b_im

   typedef enum logic [6:0] {
      ST_IDLE = 7'b000_0001,
      ST_MAC  = 7'b000_0010,
      ST_ACC  = 7'b000_0100,
      ST_DCHK = 7'b000_1000,
      ST_DIVR = 7'b001_0000,
      ST_DIVI = 7'b010_0000,
      ST_DONE = 7'b100_0000
   } state_type;

   state_type state_ff, state_in;
   req_type   q_ff;
   logic signed [DATA_W-1:0] last_re_ff, last_re_in, last_im_ff, last_im_in;
   logic [DATA_W-1:0]        cnt_ff, cnt_in;
   logic signed [PW-1:0]     acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [PW-1:0]     den_ff, den_in;
   logic signed [DATA_W-1:0] qre_ff, qre_in;
   logic                     dz_ff, dz_in;
   logic                     rv_ff, rv_in;
   rsp_type                  rsp_ff, rsp_in;
   logic [2:0]               ph_ff, ph_in;   // pass being issued

   // shared multiplier operand select and product register
   logic signed [DATA_W-1:0]   mx, my;
   logic signed [2*DATA_W-1:0] prod;
   logic signed [2*DATA_W-1:0] prod_ff;
   logic signed [PW-1:0]       prod_x;
   logic                       pv_ff;
   logic [2:0]                 pk_ff;

   div_ctl_type div_ctl;
   div_sts_type div_sts;
   logic [NUM_W-1:0] div_num, div_quo;
   logic [PW-1:0]    re_mag, im_mag;
   logic [63:0]      quo_mag;

   logic signed [DATA_W:0] sum_re, sum_im;
   logic                   accept;
   logic                   is_div;
   logic                   is_sub;
   logic [2:0]             last_pass;
   logic                   eq_hit;

   // saturate a 33-bit sum to 32-bit signed
   function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W:0] s);
      logic signed [DATA_W-1:0] r;
      if (s[DATA_W] != s[DATA_W-1])
         r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      else
         r = s[DATA_W-1:0];
      return r;
   endfunction

   assign accept    = req.valid && req.ready;
   assign is_div    = (q_ff.kind == OP_DIV);
   assign is_sub    = (q_ff.kind == OP_SUB);
   assign last_pass = is_div ? PASS_BII : PASS_RI;
   assign eq_hit    = (q_ff.kind == OP_CMP) && (q_ff.a_re == q_ff.b_re)
                      && (q_ff.a_im == q_ff.b_im);

   assign req.ready = (state_ff == ST_IDLE);

   // exact sums for add and subtract
   assign sum_re = $signed({q_ff.a_re[DATA_W-1], q_ff.a_re})
                   + (is_sub ? -$signed({q_ff.b_re[DATA_W-1], q_ff.b_re})
                             :  $signed({q_ff.b_re[DATA_W-1], q_ff.b_re}));
   assign sum_im = $signed({q_ff.a_im[DATA_W-1], q_ff.a_im})
                   + (is_sub ? -$signed({q_ff.b_im[DATA_W-1], q_ff.b_im})
                             :  $signed({q_ff.b_im[DATA_W-1], q_ff.b_im}));

   // one multiply per cycle: the pass picks the operand pair
   always_comb begin
      case (ph_ff)
         PASS_RR:  begin mx = q_ff.a_re; my = q_ff.b_re; end
         PASS_II:  begin mx = q_ff.a_im; my = q_ff.b_im; end
         PASS_IR:  begin mx = q_ff.a_im; my = q_ff.b_re; end
         PASS_RI:  begin mx = q_ff.a_re; my = q_ff.b_im; end
         PASS_BRR: begin mx = q_ff.b_re; my = q_ff.b_re; end
         default:  begin mx = q_ff.b_im; my = q_ff.b_im; end
      endcase
      prod = mx * my;
   end

   assign prod_x = {prod_ff[2*DATA_W-1], prod_ff};

   // magnitudes of the accumulated parts, divider operands and clamped quotient
   always_comb begin
      re_mag  = acc_re_ff[PW-1] ? -acc_re_ff : acc_re_ff;
      im_mag  = acc_im_ff[PW-1] ? -acc_im_ff : acc_im_ff;
      div_num = NUM_W'((state_ff == ST_DCHK) ? re_mag[DEN_W-1:0] : im_mag[DEN_W-1:0])
                << FRAC_BITS;
      quo_mag = (|div_quo[NUM_W-1:DATA_W]) ? 64'h1_0000_0000
                                           : 64'(div_quo[DATA_W-1:0]);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      last_re_in    = last_re_ff;
      last_im_in    = last_im_ff;
      cnt_in        = cnt_ff;
      acc_re_in     = acc_re_ff;
      acc_im_in     = acc_im_ff;
      den_in        = den_ff;
      qre_in        = qre_ff;
      dz_in         = dz_ff;
      ph_in         = ph_ff;
      rv_in         = rv_ff && !rsp.ready;
      rsp_in        = rsp_ff;
      div_ctl.start = 1'b0;

      // accumulate the registered product of pass pk_ff
      if (pv_ff) begin
         case (pk_ff)
            PASS_RR: acc_re_in = acc_re_ff + prod_x;
            PASS_II: acc_re_in = is_div ? acc_re_ff + prod_x : acc_re_ff - prod_x;
            PASS_IR: acc_im_in = acc_im_ff + prod_x;
            PASS_RI: acc_im_in = is_div ? acc_im_ff - prod_x : acc_im_ff + prod_x;
            default: den_in    = den_ff + prod_x;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dz_in     = 1'b0;
               ph_in     = PASS_RR;
               acc_re_in = '0;
               acc_im_in = '0;
               den_in    = '0;
               case (req.payload.kind)
                  OP_MUL, OP_DIV: state_in = ST_MAC;
                  default:        state_in = ST_DONE;
               endcase
            end
         end
         ST_MAC: begin
            ph_in = ph_ff + 3'd1;
            if (ph_ff == last_pass) state_in = ST_ACC;
         end
         ST_ACC: begin
            // last product lands this cycle
            state_in = is_div ? ST_DCHK : ST_DONE;
         end
         ST_DCHK: begin
            if (den_ff == '0) begin
               dz_in    = 1'b1;
               state_in = ST_DONE;
            end else begin
               div_ctl.start = 1'b1;
               state_in      = ST_DIVR;
            end
         end
         ST_DIVR: begin
            if (div_sts.done) begin
               qre_in        = sat_sm(acc_re_ff[PW-1], quo_mag);
               div_ctl.start = 1'b1;
               state_in      = ST_DIVI;
            end
         end
         ST_DIVI: begin
            if (div_sts.done) begin
               last_re_in = qre_ff;
               last_im_in = sat_sm(acc_im_ff[PW-1], quo_mag);
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            // commit only when the response register is free
            if (!rv_ff || rsp.ready) begin
               case (q_ff.kind)
                  OP_ADD, OP_SUB: begin
                     last_re_in = sat_add(sum_re);
                     last_im_in = sat_add(sum_im);
                  end
                  OP_MUL: begin
                     last_re_in = sat_sm(acc_re_ff[PW-1], 64'(re_mag >> FRAC_BITS));
                     last_im_in = sat_sm(acc_im_ff[PW-1], 64'(im_mag >> FRAC_BITS));
                  end
                  default: ;
               endcase
               if (q_ff.kind <= OP_CMP) cnt_in = cnt_ff + 1'b1;
               rsp_in.res_re      = last_re_in;
               rsp_in.res_im      = last_im_in;
               rsp_in.div_by_zero = dz_ff;
               rsp_in.equal       = eq_hit;
               rsp_in.ops_done    = cnt_in;
               rv_in              = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         last_re_ff <= '0;
         last_im_ff <= '0;
         cnt_ff     <= '0;
         rv_ff      <= 1'b0;
         pv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         last_re_ff <= last_re_in;
         last_im_ff <= last_im_in;
         cnt_ff     <= cnt_in;
         rv_ff      <= rv_in;
         pv_ff      <= (state_ff == ST_MAC);
      end
      if (accept) q_ff <= req.payload;
      prod_ff   <= prod;
      pk_ff     <= ph_ff;
      ph_ff     <= ph_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      den_ff    <= den_in;
      qre_ff    <= qre_in;
      dz_ff     <= dz_in;
      rsp_ff    <= rsp_in;
   end

   cau_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (den_ff[DEN_W-1:0]),
      .sts   (div_sts),
      .quo   (div_quo)
   );

   assign rsp.valid   = rv_ff;
   assign rsp.payload = rsp_ff;

   // not ready while a request is in work
   assert property (@(posedge clock) disable iff (reset)
                    state_ff != ST_IDLE |-> !req.ready)
      else $error("ready while busy");
   assert property (@(posedge clock) disable iff (reset)
                    accept |=> state_ff != ST_IDLE)
      else $error("accepted request not started");
   assert property (@(posedge clock) disable iff (reset)
                    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("response dropped or changed while stalled");
   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("sequencer state not one-hot");
endmodule
`default_nettype wire

[rtl/cau_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_divider: radix-2 restoring divider
// Unsigned NUM_W by DEN_W division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cau_divider #(
   parameter int NUM_W = 80,
   parameter int DEN_W = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cau_pkg::div_ctl_type ctl,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output cau_pkg::div_sts_type  sts,
   output logic [NUM_W-1:0]      quo
);
   import cau_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   // one shift-subtract step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      if (ctl.start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo      = quo_ff;

   // done is a single pulse after busy
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("divider done longer than one cycle");
   assert property (@(posedge clock) disable iff (reset)
                    busy_ff && !ctl.start |-> rem_ff < {1'b0, den_ff})
      else $error("divider remainder out of range");
endmodule
`default_nettype wire

[verif/tb_complex_arith_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arith_unit: self-checking bench for the complex arithmetic unit
// Random and corner-case requests go in through a queue-fed driver. A monitor
// checks each response against a behavioral predictor of the unit's state.
// ----------------------------------------------------------------------------
module tb_complex_arith_unit;
   import cau_pkg::*;

   logic clock;
   logic reset;

   cau_stream_if #(.PAYLOAD_TYPE(req_type)) req_ch ();
   cau_stream_if #(.PAYLOAD_TYPE(rsp_type)) rsp_ch ();

   complex_arith_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch.sink),
      .rsp  (rsp_ch.source)
   );

   localparam int FB = FRAC_BITS_DEF;
   localparam int STALL_LIMIT = 20000;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   // predictor state
   logic signed [31:0] pred_re, pred_im;
   logic [31:0]        pred_count;

   int  send_idle_pct, recv_idle_pct;
   bit  recv_hold;
   bit  send_pause;
   int  mismatches;
   int  idle_cycles;

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // saturate a signed wide value to 32 bits
   function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -128'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // truncating (toward zero) divide of signed values
   function automatic logic signed [127:0] trunc_div(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
      logic [127:0] mn, md, q;
      logic         neg;
      neg = (n < 0) != (d < 0);
      mn = (n < 0) ? -n : n;
      md = (d < 0) ? -d : d;
      q = mn / md;
      return neg ? -$signed(q) : $signed(q);
   endfunction

   // compute expected response and advance predictor state
   function automatic rsp_type predict_result(input req_type r);
      logic signed [127:0] ar, ai, br, bi, pr, pi, den;
      rsp_type o;
      ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
      o.div_by_zero = 1'b0;
      o.equal = 1'b0;
      case (r.kind)
         OP_ADD: begin
            pred_re = clamp32(ar + br);
            pred_im = clamp32(ai + bi);
         end
         OP_SUB: begin
            pred_re = clamp32(ar - br);
            pred_im = clamp32(ai - bi);
         end
         OP_MUL: begin
            pr = ar * br - ai * bi;
            pi = ai * br + ar * bi;
            pred_re = clamp32(trunc_div(pr, 128'sd1 <<< FB));
            pred_im = clamp32(trunc_div(pi, 128'sd1 <<< FB));
         end
         OP_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) o.div_by_zero = 1'b1;
            else begin
               pr = (ar * br + ai * bi) <<< FB;
               pi = (ai * br - ar * bi) <<< FB;
               pred_re = clamp32(trunc_div(pr, den));
               pred_im = clamp32(trunc_div(pi, den));
            end
         end
         OP_CMP: o.equal = (r.a_re == r.b_re) && (r.a_im == r.b_im);
         default: ;
      endcase
      if (r.kind <= OP_CMP) pred_count = pred_count + 1;
      o.res_re = pred_re;
      o.res_im = pred_im;
      o.ops_done = pred_count;
      return o;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
         4, 5: return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_req(input logic [2:0] k, input logic [31:0] ar,
                                        input logic [31:0] ai, input logic [31:0] br,
                                        input logic [31:0] bi);
      req_type r;
      r.kind = k; r.a_re = ar; r.a_im = ai; r.b_re = br; r.b_im = bi;
      return r;
   endfunction

   // driver: offers queued requests, random idle cycles
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid)
            expected_rsps.push_back(predict_result(req_ch.payload));
         if (pending_reqs.size() > 0 && !send_pause &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.payload <= pending_reqs.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: ready with random stalls, check responses
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_ch.payload);
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_ch.payload !== e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", e, rsp_ch.payload);
               end
            end
         end
         rsp_ch.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   task automatic add_random(input int n);
      logic [31:0] ar, ai;
      for (int i = 0; i < n; i++) begin
         ar = rand_operand();
         ai = rand_operand();
         case ($urandom_range(0, 19))
            // compare with equal real parts; imaginary parts equal or differing in bit 0
            0, 1: pending_reqs.push_back(make_req(OP_CMP, ar, ai, ar,
                                                  $urandom_range(0, 1) ? ai : ai ^ 1));
            // divide by zero
            2: pending_reqs.push_back(make_req(OP_DIV, ar, ai, 0, 0));
            // unused kind
            3: pending_reqs.push_back(make_req(3'($urandom_range(5, 7)), ar, ai,
                                               rand_operand(), rand_operand()));
            default: pending_reqs.push_back(make_req(3'($urandom_range(0, 4)), ar, ai,
                                                     rand_operand(), rand_operand()));
         endcase
      end
   endtask

   initial begin
      logic [31:0] mx, mn;
      mx = 32'h7FFF_FFFF; mn = 32'h8000_0000;
      reset = 1'b1;
      clock = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      pred_re = 0; pred_im = 0; pred_count = 0;
      mismatches = 0; idle_cycles = 0;
      recv_hold = 1'b0; send_pause = 1'b0;
      send_idle_pct = 35; recv_idle_pct = 63;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      pending_reqs.push_back(make_req(OP_ADD, mx, mn, mx, mn));
      pending_reqs.push_back(make_req(OP_SUB, mx, mn, mn, mx));
      pending_reqs.push_back(make_req(OP_ADD, 32'h0001_8000, 32'hFFFF_0000, 1, 2));
      pending_reqs.push_back(make_req(OP_MUL, mx, mx, mx, mn));
      pending_reqs.push_back(make_req(OP_MUL, mn, mn, mn, mn));
      pending_reqs.push_back(make_req(OP_MUL, 32'hFFFF_FFFF, 0, 1, 0));
      pending_reqs.push_back(make_req(OP_MUL, 32'h0002_0000, 32'h0001_0000,
                                      32'h0003_0000, 32'hFFFF_0000));
      pending_reqs.push_back(make_req(OP_DIV, 5, 7, 0, 0));
      pending_reqs.push_back(make_req(OP_DIV, mx, mn, 1, 0));
      pending_reqs.push_back(make_req(OP_DIV, mn, mx, mn, mn));
      pending_reqs.push_back(make_req(OP_DIV, 32'h0001_0000, 0, 32'h0003_0000, 0));
      pending_reqs.push_back(make_req(OP_DIV, 32'hFFFF_FFFF, 1, mx, mx));
      pending_reqs.push_back(make_req(OP_CMP, mx, mn, mx, mn));
      pending_reqs.push_back(make_req(OP_CMP, mx, mn, mx, mx));
      pending_reqs.push_back(make_req(OP_CMP, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(3'd5, 1, 2, 3, 4));
      pending_reqs.push_back(make_req(3'd7, mx, mx, mx, mx));
      pending_reqs.push_back(make_req(3'd6, mn, 0, 0, 0));
      add_random(280);
      wait_drained();

      // swapped idling; long receiver hold while requests keep coming
      send_idle_pct = 63; recv_idle_pct = 35;
      add_random(280);
      recv_hold = 1'b1;
      repeat (400) @(posedge clock);
      recv_hold = 1'b0;
      // sender pause until everything has come back
      send_pause = 1'b1;
      while (expected_rsps.size() > 0 || req_ch.valid) @(posedge clock);
      send_pause = 1'b0;
      wait_drained();

      // no idling
      send_idle_pct = 0; recv_idle_pct = 0;
      add_random(280);
      wait_drained();
      repeat (300) @(posedge clock);

      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
